@@ design/vtp_pkg.sv @@
// Package for the VT100 escape parser: result types, command codes, defaults.
`timescale 1ns / 1ps
`default_nettype none

package vtp_pkg;

  // Default depth of the parameter counter range.
  localparam int unsigned MAX_PARAMS_DEF = 8;

  // Result queue depth; holds two beats per byte with room for one in flight.
  localparam int unsigned RES_DEPTH = 4;

  localparam logic [7:0] SCREEN_ROWS_RESET = 8'd24;

  // Result kinds.
  localparam logic [4:0] KIND_BYTE      = 5'd0;
  localparam logic [4:0] KIND_UP        = 5'd1;
  localparam logic [4:0] KIND_DOWN      = 5'd2;
  localparam logic [4:0] KIND_RIGHT     = 5'd3;
  localparam logic [4:0] KIND_LEFT      = 5'd4;
  localparam logic [4:0] KIND_MOVE_ABS  = 5'd5;
  localparam logic [4:0] KIND_ERASE_DSP = 5'd6;
  localparam logic [4:0] KIND_ERASE_LN  = 5'd7;
  localparam logic [4:0] KIND_SAVE      = 5'd8;
  localparam logic [4:0] KIND_RESTORE   = 5'd9;
  localparam logic [4:0] KIND_IL        = 5'd10;
  localparam logic [4:0] KIND_DL        = 5'd11;
  localparam logic [4:0] KIND_ICH       = 5'd12;
  localparam logic [4:0] KIND_DCH       = 5'd13;
  localparam logic [4:0] KIND_ECH       = 5'd14;
  localparam logic [4:0] KIND_SU        = 5'd15;
  localparam logic [4:0] KIND_SD        = 5'd16;
  localparam logic [4:0] KIND_RESET     = 5'd17;

  typedef struct packed {
    logic [4:0] kind;
    logic [7:0] out_byte;
    logic [7:0] arg_a;
    logic [7:0] arg_b;
    logic       last;
  } res_t;

  // Results caused by one byte: up to two beats.
  typedef struct packed {
    logic [1:0] num;
    res_t       r0;
    res_t       r1;
  } push_t;

endpackage

`default_nettype wire

@@ design/vtp_parser.sv @@
// Parser state and single-pass decode of one received byte.
`timescale 1ns / 1ps
`default_nettype none

module vtp_parser #(
  parameter int unsigned MaxParams = vtp_pkg::MAX_PARAMS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  wire logic [7:0]    byte_i,
  input  wire logic [7:0]    screen_rows_i,
  output vtp_pkg::push_t     push_o
);

  localparam int unsigned CntW = $clog2(MaxParams + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxParams);

  localparam logic [1:0] ST_NORMAL = 2'd0;
  localparam logic [1:0] ST_ESC    = 2'd1;
  localparam logic [1:0] ST_CSI    = 2'd2;

  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] TR_EOL = 8'h9B;
  localparam logic [7:0] TR_BS  = 8'h7E;
  localparam logic [7:0] TR_TAB = 8'h7F;
  localparam logic [7:0] TR_BEL = 8'hFD;
  localparam logic [7:0] TR_CLR = 8'h7D;

  logic [1:0]      state_q, state_d;
  logic [7:0]      first_q, first_d;
  logic [7:0]      second_q, second_d;
  logic [CntW-1:0] count_q, count_d;
  logic [7:0]      cur_q, cur_d;
  logic            saw_q, saw_d;
  logic            after_cr_q, after_cr_d;
  logic [7:0]      top_q, top_d;
  logic [7:0]      bot_q, bot_d;

  // Parameter values as seen at the final byte (after the last store).
  logic [7:0]      st_first, st_second, n1, n2, n1_def, n2_def;
  logic [CntW-1:0] st_count;
  logic [7:0]      full_bot, r_top, r_bot;
  logic            full;
  logic [7:0]      cur_x10;

  vtp_pkg::res_t   r0, r1;
  logic [1:0]      num;

  always_comb begin
    st_first  = first_q;
    st_second = second_q;
    st_count  = count_q;
    if (count_q < CntMax) begin
      if (count_q == '0) begin
        st_first = cur_q;
      end else if (count_q == CntW'(1)) begin
        st_second = cur_q;
      end
      st_count = count_q + CntW'(1);
    end
    n1       = saw_q ? st_first : 8'd0;
    n2       = (st_count >= CntW'(2)) ? st_second : 8'd0;
    n1_def   = (n1 == 8'd0) ? 8'd1 : n1;
    n2_def   = (n2 == 8'd0) ? 8'd1 : n2;
    full_bot = screen_rows_i - 8'd1;
    full     = (top_q == 8'd0) && (bot_q == full_bot);
    r_top    = (n1 != 8'd0) ? n1 - 8'd1 : 8'd0;
    r_bot    = (n2 != 8'd0) ? n2 - 8'd1 : full_bot;
    cur_x10  = {cur_q[4:0], 3'b000} + {cur_q[6:0], 1'b0};
  end

  always_comb begin
    state_d    = state_q;
    first_d    = first_q;
    second_d   = second_q;
    count_d    = count_q;
    cur_d      = cur_q;
    saw_d      = saw_q;
    after_cr_d = after_cr_q;
    top_d      = top_q;
    bot_d      = bot_q;
    r0         = '0;
    r1         = '0;
    num        = 2'd0;

    unique case (state_q)
      ST_ESC: begin
        state_d = ST_NORMAL;
        if (byte_i == "[") begin
          state_d  = ST_CSI;
          first_d  = 8'd0;
          second_d = 8'd0;
          count_d  = '0;
          cur_d    = 8'd0;
          saw_d    = 1'b0;
        end else if (byte_i == "7") begin
          r0.kind = vtp_pkg::KIND_SAVE;
          num     = 2'd1;
        end else if (byte_i == "8") begin
          r0.kind = vtp_pkg::KIND_RESTORE;
          num     = 2'd1;
        end else if (byte_i == "c") begin
          first_d     = 8'd0;
          second_d    = 8'd0;
          count_d     = '0;
          cur_d       = 8'd0;
          saw_d       = 1'b0;
          after_cr_d  = 1'b0;
          top_d       = 8'd0;
          bot_d       = full_bot;
          r0.kind     = vtp_pkg::KIND_RESET;
          r1.kind     = vtp_pkg::KIND_BYTE;
          r1.out_byte = TR_CLR;
          num         = 2'd2;
        end
      end
      ST_CSI: begin
        if (byte_i >= "0" && byte_i <= "9") begin
          saw_d = 1'b1;
          cur_d = cur_x10 + (byte_i - "0");
        end else if (byte_i == ";") begin
          first_d  = st_first;
          second_d = st_second;
          count_d  = st_count;
          cur_d    = 8'd0;
          saw_d    = 1'b1;
        end else if (byte_i == "?" || byte_i == ">" || byte_i == "=") begin
          state_d = ST_CSI;
        end else begin
          // Final byte: store the open value, then dispatch.
          first_d  = st_first;
          second_d = st_second;
          count_d  = st_count;
          state_d  = ST_NORMAL;
          r0.arg_a = n1_def;
          num      = 2'd1;
          unique case (byte_i)
            "A": r0.kind = vtp_pkg::KIND_UP;
            "B": r0.kind = vtp_pkg::KIND_DOWN;
            "C": r0.kind = vtp_pkg::KIND_RIGHT;
            "D": r0.kind = vtp_pkg::KIND_LEFT;
            "H", "f": begin
              r0.kind  = vtp_pkg::KIND_MOVE_ABS;
              r0.arg_b = n2_def;
            end
            "J": begin
              r0.kind  = vtp_pkg::KIND_ERASE_DSP;
              r0.arg_a = n1;
            end
            "K": begin
              r0.kind  = vtp_pkg::KIND_ERASE_LN;
              r0.arg_a = n1;
            end
            "s": begin
              r0.kind  = vtp_pkg::KIND_SAVE;
              r0.arg_a = 8'd0;
            end
            "u": begin
              r0.kind  = vtp_pkg::KIND_RESTORE;
              r0.arg_a = 8'd0;
            end
            "L": r0.kind = vtp_pkg::KIND_IL;
            "M": r0.kind = vtp_pkg::KIND_DL;
            "@": r0.kind = vtp_pkg::KIND_ICH;
            "P": r0.kind = vtp_pkg::KIND_DCH;
            "X": r0.kind = vtp_pkg::KIND_ECH;
            "S": begin
              r0.kind = vtp_pkg::KIND_SU;
              num     = full ? 2'd1 : 2'd0;
            end
            "T": begin
              r0.kind = vtp_pkg::KIND_SD;
              num     = full ? 2'd1 : 2'd0;
            end
            "r": begin
              r0.kind  = vtp_pkg::KIND_MOVE_ABS;
              r0.arg_a = 8'd1;
              r0.arg_b = 8'd1;
              if (r_top < screen_rows_i && r_bot < screen_rows_i && r_top < r_bot) begin
                top_d = r_top;
                bot_d = r_bot;
              end else begin
                top_d = 8'd0;
                bot_d = full_bot;
              end
            end
            default: begin
              r0  = '0;
              num = 2'd0;
            end
          endcase
        end
      end
      default: begin
        state_d = ST_NORMAL;
        if (byte_i == CH_ESC) begin
          state_d = ST_ESC;
        end else if (byte_i == CH_CR) begin
          after_cr_d  = 1'b1;
          r0.out_byte = TR_EOL;
          num         = 2'd1;
        end else if (byte_i == CH_LF) begin
          if (after_cr_q) begin
            after_cr_d = 1'b0;
          end else begin
            r0.out_byte = TR_EOL;
            num         = 2'd1;
          end
        end else begin
          after_cr_d = 1'b0;
          num        = 2'd1;
          unique case (byte_i)
            CH_BS:   r0.out_byte = TR_BS;
            CH_TAB:  r0.out_byte = TR_TAB;
            CH_BEL:  r0.out_byte = TR_BEL;
            default: r0.out_byte = {1'b0, byte_i[6:0]};
          endcase
        end
      end
    endcase

    r0.last = (num == 2'd1);
    r1.last = (num == 2'd2);
  end

  assign push_o.num = fire_i ? num : 2'd0;
  assign push_o.r0  = r0;
  assign push_o.r1  = r1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_NORMAL;
      first_q    <= 8'd0;
      second_q   <= 8'd0;
      count_q    <= '0;
      cur_q      <= 8'd0;
      saw_q      <= 1'b0;
      after_cr_q <= 1'b0;
      top_q      <= 8'd0;
      bot_q      <= vtp_pkg::SCREEN_ROWS_RESET - 8'd1;
    end else if (fire_i) begin
      state_q    <= state_d;
      first_q    <= first_d;
      second_q   <= second_d;
      count_q    <= count_d;
      cur_q      <= cur_d;
      saw_q      <= saw_d;
      after_cr_q <= after_cr_d;
      top_q      <= top_d;
      bot_q      <= bot_d;
    end
  end

endmodule

`default_nettype wire

@@ design/vtp_result_fifo.sv @@
// Result queue: takes up to two beats per cycle, hands out one.
`timescale 1ns / 1ps
`default_nettype none

module vtp_result_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire vtp_pkg::push_t push_i,
  input  wire logic           pop_i,
  output logic                valid_o,
  output logic                room2_o,
  output vtp_pkg::res_t       head_o
);

  localparam int unsigned Depth = vtp_pkg::RES_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  vtp_pkg::res_t   mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q, after_pop;
  logic            do_pop;

  assign valid_o   = (count_q != '0);
  assign do_pop    = pop_i && valid_o;
  assign after_pop = count_q - CntW'(do_pop);
  assign room2_o   = (after_pop <= CntW'(Depth - 2));
  assign head_o    = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wptr_q] <= push_i.r0;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wptr_q + PtrW'(1)] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + PtrW'(push_i.num);
      rptr_q  <= rptr_q + PtrW'(do_pop);
      count_q <= after_pop + CntW'(push_i.num);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("result queue overflow");
  a_push_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num != 2'd0) |-> (after_pop + CntW'(push_i.num) <= CntW'(Depth)))
    else $error("push without room");
`endif

endmodule

`default_nettype wire

@@ design/vt100_escape_parser_top.sv @@
// Top level of the VT100/ANSI escape sequence parser.
// Usage:
//   Receive channel: rx_valid_i / rx_stall_o carry one byte per beat on
//   rx_byte_i. A beat is taken on a rising edge with valid high, stall low.
//   Result channel: res_valid_o / res_stall_i carry one result per beat
//   (kind_o, out_byte_o, arg_a_o, arg_b_o, last_o). A byte yields zero, one
//   or two results; last_o marks the final one of a byte.
//   Config channel: cfg_valid_i / cfg_ready_o write screen_rows from
//   cfg_data_i; ready is always high. Write only while the block is idle.
// Timing:
//   One byte per cycle sustained while the result queue has room. A byte
//   is held in the input register, then decoded in a single pass, and its
//   results are written into a four-entry result queue.
//   A byte moves on only when the queue has room for two results, so the
//   queue depth sets how long a stalled receiver can be covered.
// Reset:
//   Asynchronous, active low. Parser returns to normal state, screen_rows
//   becomes 24 and the scroll region spans the full screen.
// Stall: when res_stall_i holds, results wait in the queue; without room for
//   two results, rx_stall_o rises; the byte holds in the input register.
`timescale 1ns / 1ps
`default_nettype none

module vt100_escape_parser_top #(
  parameter int unsigned MaxParams = vtp_pkg::MAX_PARAMS_DEF
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // receive channel
  input  wire logic       rx_valid_i,
  output logic            rx_stall_o,
  input  wire logic [7:0] rx_byte_i,
  // result channel
  output logic            res_valid_o,
  input  wire logic       res_stall_i,
  output logic [4:0]      kind_o,
  output logic [7:0]      out_byte_o,
  output logic [7:0]      arg_a_o,
  output logic [7:0]      arg_b_o,
  output logic            last_o,
  // config channel
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [7:0] cfg_data_i
);

  logic           in_valid_q;
  logic [7:0]     in_byte_q;
  logic [7:0]     rows_q;
  logic           room2, fire, rx_take;
  vtp_pkg::push_t push;
  vtp_pkg::res_t  head;

  // Decode fires when a byte is held and the queue can take two results.
  assign fire       = in_valid_q && room2;
  assign rx_stall_o = in_valid_q && !fire;
  assign rx_take    = rx_valid_i && !rx_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= rx_take || (in_valid_q && !fire);
    end
  end

  // Byte register carries no reset; valid qualifies it.
  always_ff @(posedge clk_i) begin
    if (rx_take) begin
      in_byte_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= vtp_pkg::SCREEN_ROWS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rows_q <= cfg_data_i;
    end
  end

  vtp_parser #(
    .MaxParams(MaxParams)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (fire),
    .byte_i       (in_byte_q),
    .screen_rows_i(rows_q),
    .push_o       (push)
  );

  vtp_result_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (!res_stall_i),
    .valid_o(res_valid_o),
    .room2_o(room2),
    .head_o (head)
  );

  assign kind_o     = head.kind;
  assign out_byte_o = head.out_byte;
  assign arg_a_o    = head.arg_a;
  assign arg_b_o    = head.arg_b;
  assign last_o     = head.last;

`ifndef SYNTHESIS
  a_stall_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_stall_o |-> in_valid_q)
    else $error("stall with empty input register");
  a_cmd_no_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && kind_o != vtp_pkg::KIND_BYTE) |-> (out_byte_o == 8'd0))
    else $error("command beat carries a byte");
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (kind_o <= vtp_pkg::KIND_RESET))
    else $error("result kind out of range");
  a_held_byte_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_stall_o |=> $stable(in_byte_q))
    else $error("held byte changed under stall");
`endif

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Testbench for the VT100 escape parser: directed byte table, then random streams.
`timescale 1ns / 1ps

module testbench;

  // Control characters seen on the receive side.
  localparam logic [7:0] CH_ESC = 8'h1B;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_BS  = 8'h08;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_BEL = 8'h07;
  localparam logic [7:0] CH_CSI8 = 8'h9B;

  // Terminal bytes emitted by the translator.
  localparam logic [7:0] OUT_EOL = 8'h9B;
  localparam logic [7:0] OUT_BS  = 8'h7E;
  localparam logic [7:0] OUT_TAB = 8'h7F;
  localparam logic [7:0] OUT_BEL = 8'hFD;
  localparam logic [7:0] OUT_CLR = 8'h7D;

  localparam int unsigned STALL_MAX      = 12;
  localparam int unsigned DRAIN_CYCLES   = 12;
  localparam int unsigned WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int unsigned PHASE_ITEMS    = 315;   // five random phases, about 1600 bytes in all
  localparam int unsigned SHOWN_MAX      = 10;

  // Finals weighted toward the region and scroll commands.
  localparam string CSI_FINALS = "ABCDHfJKsuLM@PXSTrrrSSTTm";
  localparam string ESC_TAILS  = "77788c";

  typedef enum logic [1:0] {PS_TEXT, PS_ESC, PS_CSI} parse_e;

  typedef struct {
    logic [7:0] rx;
    logic       pinned;   // typed expectation replaces the prediction
    logic       has_res;
    logic [4:0] kind;
    logic [7:0] ob;
    logic [7:0] a;
    logic [7:0] b;
  } row_t;

  logic       clk_i;
  logic       rst_ni;
  logic       rx_valid_i;
  logic       rx_stall_o;
  logic [7:0] rx_byte_i;
  logic       res_valid_o;
  logic       res_stall_i;
  logic [4:0] kind_o;
  logic [7:0] out_byte_o;
  logic [7:0] arg_a_o;
  logic [7:0] arg_b_o;
  logic       last_o;
  logic       cfg_valid_i;
  logic       cfg_ready_o;
  logic [7:0] cfg_data_i;

  // Typed expectation riding along with the byte beat.
  logic          pin_on;
  logic          pin_has;
  vtp_pkg::res_t pin_res;

  // Parser shadow state.
  parse_e     pstate;
  logic [7:0] rows_cfg;
  logic [7:0] p_first;
  logic [7:0] p_second;
  logic [3:0] p_count;
  logic [7:0] acc_val;
  logic       saw_arg;
  logic       cr_seen;
  logic [7:0] top_row;
  logic [7:0] bot_row;

  vtp_pkg::res_t fresh_q[$];  // results of the byte just decoded
  vtp_pkg::res_t exp_q[$];    // results still owed by the block
  logic [7:0]    plan_q[$];   // random bytes waiting to be sent
  row_t          dir_rows[25];

  int unsigned   fails;
  int unsigned   bytes_in;
  int unsigned   beats_out;
  int unsigned   rows_writes;
  int unsigned   idle_cycles;
  int unsigned   hold_left;
  bit            src_burst;
  bit            sink_burst;
  bit            rx_up;
  vtp_pkg::res_t got;
  vtp_pkg::res_t want;

  vt100_escape_parser_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_valid_i  (rx_valid_i),
    .rx_stall_o  (rx_stall_o),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid_o),
    .res_stall_i (res_stall_i),
    .kind_o      (kind_o),
    .out_byte_o  (out_byte_o),
    .arg_a_o     (arg_a_o),
    .arg_b_o     (arg_b_o),
    .last_o      (last_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Shadow parser
  // ---------------------------------------------------------------------------

  function automatic vtp_pkg::res_t mk(input logic [4:0] k, input logic [7:0] ob,
                                       input logic [7:0] a, input logic [7:0] b);
    vtp_pkg::res_t r;
    r.kind     = k;
    r.out_byte = ob;
    r.arg_a    = a;
    r.arg_b    = b;
    r.last     = 1'b0;
    return r;
  endfunction

  function automatic logic [7:0] nz(input logic [7:0] v);
    return (v == 8'd0) ? 8'd1 : v;
  endfunction

  // Full parser clear, as on RIS; the row count is kept.
  task automatic clear_parser();
    pstate   = PS_TEXT;
    p_first  = '0;
    p_second = '0;
    p_count  = '0;
    acc_val  = '0;
    saw_arg  = 1'b0;
    cr_seen  = 1'b0;
    top_row  = '0;
    bot_row  = rows_cfg - 8'd1;
  endtask

  // Only the first two parameters are kept; the count saturates.
  task automatic stash_param();
    if (p_count < vtp_pkg::MAX_PARAMS_DEF) begin
      if (p_count == 4'd0) p_first = acc_val;
      else if (p_count == 4'd1) p_second = acc_val;
      p_count = p_count + 4'd1;
    end
  endtask

  task automatic run_final(input logic [7:0] c);
    logic [7:0] n1;
    logic [7:0] n2;
    logic [7:0] full_bot;
    logic [7:0] top;
    logic [7:0] bot;
    logic       full;
    n1       = saw_arg ? p_first : 8'd0;
    n2       = (p_count >= 4'd2) ? p_second : 8'd0;
    full_bot = rows_cfg - 8'd1;
    full     = (top_row == 8'd0) && (bot_row == full_bot);
    case (c)
      "A": fresh_q.push_back(mk(vtp_pkg::KIND_UP, 8'd0, nz(n1), 8'd0));
      "B": fresh_q.push_back(mk(vtp_pkg::KIND_DOWN, 8'd0, nz(n1), 8'd0));
      "C": fresh_q.push_back(mk(vtp_pkg::KIND_RIGHT, 8'd0, nz(n1), 8'd0));
      "D": fresh_q.push_back(mk(vtp_pkg::KIND_LEFT, 8'd0, nz(n1), 8'd0));
      "H", "f": fresh_q.push_back(mk(vtp_pkg::KIND_MOVE_ABS, 8'd0, nz(n1), nz(n2)));
      "J": fresh_q.push_back(mk(vtp_pkg::KIND_ERASE_DSP, 8'd0, n1, 8'd0));
      "K": fresh_q.push_back(mk(vtp_pkg::KIND_ERASE_LN, 8'd0, n1, 8'd0));
      "s": fresh_q.push_back(mk(vtp_pkg::KIND_SAVE, 8'd0, 8'd0, 8'd0));
      "u": fresh_q.push_back(mk(vtp_pkg::KIND_RESTORE, 8'd0, 8'd0, 8'd0));
      "L": fresh_q.push_back(mk(vtp_pkg::KIND_IL, 8'd0, nz(n1), 8'd0));
      "M": fresh_q.push_back(mk(vtp_pkg::KIND_DL, 8'd0, nz(n1), 8'd0));
      "@": fresh_q.push_back(mk(vtp_pkg::KIND_ICH, 8'd0, nz(n1), 8'd0));
      "P": fresh_q.push_back(mk(vtp_pkg::KIND_DCH, 8'd0, nz(n1), 8'd0));
      "X": fresh_q.push_back(mk(vtp_pkg::KIND_ECH, 8'd0, nz(n1), 8'd0));
      "S": if (full) fresh_q.push_back(mk(vtp_pkg::KIND_SU, 8'd0, nz(n1), 8'd0));
      "T": if (full) fresh_q.push_back(mk(vtp_pkg::KIND_SD, 8'd0, nz(n1), 8'd0));
      "r": begin
        // bad regions fall back to the whole screen; home either way
        top = (n1 != 8'd0) ? n1 - 8'd1 : 8'd0;
        bot = (n2 != 8'd0) ? n2 - 8'd1 : full_bot;
        if (top < rows_cfg && bot < rows_cfg && top < bot) begin
          top_row = top;
          bot_row = bot;
        end else begin
          top_row = 8'd0;
          bot_row = full_bot;
        end
        fresh_q.push_back(mk(vtp_pkg::KIND_MOVE_ABS, 8'd0, 8'd1, 8'd1));
      end
      default: ;
    endcase
  endtask

  task automatic decode_byte(input logic [7:0] c);
    vtp_pkg::res_t tail;
    fresh_q.delete();
    case (pstate)
      PS_ESC: begin
        pstate = PS_TEXT;
        if (c == "[") begin
          pstate   = PS_CSI;
          p_first  = '0;
          p_second = '0;
          p_count  = '0;
          acc_val  = '0;
          saw_arg  = 1'b0;
        end else if (c == "7") begin
          fresh_q.push_back(mk(vtp_pkg::KIND_SAVE, 8'd0, 8'd0, 8'd0));
        end else if (c == "8") begin
          fresh_q.push_back(mk(vtp_pkg::KIND_RESTORE, 8'd0, 8'd0, 8'd0));
        end else if (c == "c") begin
          clear_parser();
          fresh_q.push_back(mk(vtp_pkg::KIND_RESET, 8'd0, 8'd0, 8'd0));
          fresh_q.push_back(mk(vtp_pkg::KIND_BYTE, OUT_CLR, 8'd0, 8'd0));
        end
      end
      PS_CSI: begin
        if (c >= "0" && c <= "9") begin
          saw_arg = 1'b1;
          acc_val = acc_val * 8'd10 + (c - "0");
        end else if (c == ";") begin
          stash_param();
          acc_val = '0;
          saw_arg = 1'b1;
        end else if (c == "?" || c == ">" || c == "=") begin
          // private markers pass through
        end else begin
          // anything else ends the sequence, ESC included
          stash_param();
          run_final(c);
          pstate = PS_TEXT;
        end
      end
      default: begin
        if (c == CH_ESC) begin
          pstate = PS_ESC;
        end else if (c == CH_CR) begin
          cr_seen = 1'b1;
          fresh_q.push_back(mk(vtp_pkg::KIND_BYTE, OUT_EOL, 8'd0, 8'd0));
        end else if (c == CH_LF) begin
          // LF straight after CR is folded into it
          if (cr_seen) cr_seen = 1'b0;
          else fresh_q.push_back(mk(vtp_pkg::KIND_BYTE, OUT_EOL, 8'd0, 8'd0));
        end else begin
          cr_seen = 1'b0;
          case (c)
            CH_BS:   fresh_q.push_back(mk(vtp_pkg::KIND_BYTE, OUT_BS, 8'd0, 8'd0));
            CH_TAB:  fresh_q.push_back(mk(vtp_pkg::KIND_BYTE, OUT_TAB, 8'd0, 8'd0));
            CH_BEL:  fresh_q.push_back(mk(vtp_pkg::KIND_BYTE, OUT_BEL, 8'd0, 8'd0));
            default: fresh_q.push_back(mk(vtp_pkg::KIND_BYTE, c & 8'h7F, 8'd0, 8'd0));
          endcase
        end
      end
    endcase
    if (fresh_q.size() > 0) begin
      tail      = fresh_q.pop_back();
      tail.last = 1'b1;
      fresh_q.push_back(tail);
    end
  endtask

  task automatic flag_beat(input string why, input vtp_pkg::res_t w,
                           input vtp_pkg::res_t g);
    fails++;
    if (fails <= SHOWN_MAX)
      $display({"mismatch %0d (%s): expected kind=%0d byte=%02h a=%0d b=%0d last=%0b,",
                " got kind=%0d byte=%02h a=%0d b=%0d last=%0b"},
               fails, why, w.kind, w.out_byte, w.arg_a, w.arg_b, w.last,
               g.kind, g.out_byte, g.arg_a, g.arg_b, g.last);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor: config and byte beats feed the shadow parser, result beats are
  // checked in order. Watchdog counts edges with no beat on any channel.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      idle_cycles++;
      if (cfg_valid_i && cfg_ready_o) begin
        rows_cfg    = cfg_data_i;
        idle_cycles = 0;
      end
      if (rx_valid_i && !rx_stall_o) begin
        decode_byte(rx_byte_i);
        if (pin_on) begin
          if (pin_has) exp_q.push_back(pin_res);
        end else begin
          foreach (fresh_q[i]) exp_q.push_back(fresh_q[i]);
        end
        bytes_in++;
        idle_cycles = 0;
      end
      if (res_valid_o && !res_stall_i) begin
        got.kind     = kind_o;
        got.out_byte = out_byte_o;
        got.arg_a    = arg_a_o;
        got.arg_b    = arg_b_o;
        got.last     = last_o;
        if (exp_q.size() == 0) begin
          flag_beat("unexpected beat", '0, got);
        end else begin
          want = exp_q.pop_front();
          if (got !== want) flag_beat("wrong fields", want, got);
        end
        beats_out++;
        idle_cycles = 0;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d quiet cycles, %0d results still owed",
                 idle_cycles, exp_q.size());
        $display("FAIL vt100_escape_parser_top");
        $finish;
      end
    end
  end

  // Result-side back-pressure: a random hold after each beat, with calm spells.
  always @(posedge clk_i) begin
    if (res_valid_o && !res_stall_i) begin
      if ($urandom_range(0, 39) == 0) sink_burst = ~sink_burst;
      hold_left = sink_burst ? 0 : $urandom_range(0, STALL_MAX);
    end
    if (hold_left > 0) begin
      res_stall_i <= 1'b1;
      hold_left--;
    end else begin
      res_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // One byte beat after a random gap; returns on the accepting edge.
  task automatic send_byte(input logic [7:0] b, input logic pinned, input logic has,
                           input vtp_pkg::res_t r);
    int unsigned gap;
    if ($urandom_range(0, 39) == 0) src_burst = ~src_burst;
    gap = src_burst ? 0 : $urandom_range(0, STALL_MAX);
    if (gap > 0) begin
      if (rx_up) rx_valid_i <= 1'b0;
      rx_up = 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    pin_on     <= pinned;
    pin_has    <= has;
    pin_res    <= r;
    rx_up = 1'b1;
    @(posedge clk_i);
    while (rx_stall_o) @(posedge clk_i);
  endtask

  // Drop valid and wait until every owed result is out, plus some slack.
  task automatic settle(input int unsigned extra);
    if (rx_up) rx_valid_i <= 1'b0;
    rx_up = 1'b0;
    @(posedge clk_i);
    while (exp_q.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic set_rows(input logic [7:0] v);
    settle(DRAIN_CYCLES);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    rows_writes++;
  endtask

  // Queue up one random fragment: mostly real sequences, some noise.
  task automatic build_chunk();
    int unsigned pick;
    int unsigned nparams;
    int unsigned v;
    string       digits;
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      plan_q.push_back(CH_ESC);
      plan_q.push_back("[");
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0:       plan_q.push_back("?");
          1:       plan_q.push_back(">");
          default: plan_q.push_back("=");
        endcase
      end
      // now and then enough parameters to saturate the counter
      nparams = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 11) : $urandom_range(0, 3);
      for (int k = 0; k < nparams; k++) begin
        if (k > 0) plan_q.push_back(";");
        if ($urandom_range(0, 5) != 0) begin
          v = $urandom_range(0, 1) ? $urandom_range(0, rows_cfg + 2) : $urandom_range(0, 999);
          digits = $sformatf("%0d", v);
          if ($urandom_range(0, 7) == 0) plan_q.push_back("0");
          for (int i = 0; i < digits.len(); i++) plan_q.push_back(digits[i]);
        end
      end
      pick = $urandom_range(0, 19);
      if (pick < 17) plan_q.push_back(CSI_FINALS[$urandom_range(0, CSI_FINALS.len() - 1)]);
      else if (pick == 17) plan_q.push_back(CH_ESC);
      else plan_q.push_back(8'($urandom_range(0, 255)));
    end else if (pick < 55) begin
      plan_q.push_back(CH_ESC);
      if ($urandom_range(0, 4) == 0) plan_q.push_back(8'($urandom_range(0, 255)));
      else plan_q.push_back(ESC_TAILS[$urandom_range(0, ESC_TAILS.len() - 1)]);
    end else if (pick < 65) begin
      plan_q.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
      if ($urandom_range(0, 1)) plan_q.push_back(CH_LF);
      if ($urandom_range(0, 3) == 0) plan_q.push_back(CH_LF);
    end else if (pick < 70) begin
      // broken sequence: CSI opener followed by junk
      plan_q.push_back(CH_ESC);
      plan_q.push_back("[");
      repeat ($urandom_range(1, 3)) plan_q.push_back(8'($urandom_range(0, 255)));
    end else if ($urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       plan_q.push_back(CH_BS);
        1:       plan_q.push_back(CH_TAB);
        2:       plan_q.push_back(CH_BEL);
        default: plan_q.push_back(CH_CSI8);
      endcase
    end else begin
      plan_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_phase(input int unsigned items);
    for (int unsigned n = 0; n < items; n++) begin
      // once in a while the sender holds off until the block has drained
      if ($urandom_range(0, 149) == 0) settle(0);
      if (plan_q.size() == 0) build_chunk();
      send_byte(plan_q.pop_front(), 1'b0, 1'b0, '0);
    end
  endtask

  initial begin
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    rx_valid_i  = 1'b0;
    rx_byte_i   = '0;
    res_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    pin_on      = 1'b0;
    pin_has     = 1'b0;
    pin_res     = '0;
    fails       = 0;
    bytes_in    = 0;
    beats_out   = 0;
    rows_writes = 0;
    idle_cycles = 0;
    hold_left   = 0;
    src_burst   = 1'b0;
    sink_burst  = 1'b0;
    rx_up       = 1'b0;
    rows_cfg    = vtp_pkg::SCREEN_ROWS_RESET;
    clear_parser();

    // Directed bytes at reset row count. Typed rows are obvious from the
    // translation rules; the rest go through the shadow parser.
    dir_rows = '{
      '{8'h00, 1'b1, 1'b1, vtp_pkg::KIND_BYTE,    8'h00,   8'd0,   8'd0},
      '{8'hFF, 1'b1, 1'b1, vtp_pkg::KIND_BYTE,    8'h7F,   8'd0,   8'd0},
      '{CH_CR, 1'b1, 1'b1, vtp_pkg::KIND_BYTE,    OUT_EOL, 8'd0,   8'd0},
      '{CH_LF, 1'b1, 1'b0, vtp_pkg::KIND_BYTE,    8'h00,   8'd0,   8'd0},  // merged into CR
      '{CH_LF, 1'b1, 1'b1, vtp_pkg::KIND_BYTE,    OUT_EOL, 8'd0,   8'd0},
      '{CH_BS, 1'b1, 1'b1, vtp_pkg::KIND_BYTE,    OUT_BS,  8'd0,   8'd0},
      '{CH_TAB, 1'b1, 1'b1, vtp_pkg::KIND_BYTE,   OUT_TAB, 8'd0,   8'd0},
      '{CH_BEL, 1'b1, 1'b1, vtp_pkg::KIND_BYTE,   OUT_BEL, 8'd0,   8'd0},
      '{CH_ESC, 1'b1, 1'b0, vtp_pkg::KIND_BYTE,   8'h00,   8'd0,   8'd0},
      '{"7",   1'b1, 1'b1, vtp_pkg::KIND_SAVE,    8'h00,   8'd0,   8'd0},
      '{CH_ESC, 1'b1, 1'b0, vtp_pkg::KIND_BYTE,   8'h00,   8'd0,   8'd0},
      '{"8",   1'b1, 1'b1, vtp_pkg::KIND_RESTORE, 8'h00,   8'd0,   8'd0},
      '{CH_ESC, 1'b1, 1'b0, vtp_pkg::KIND_BYTE,   8'h00,   8'd0,   8'd0},
      '{"[",   1'b1, 1'b0, vtp_pkg::KIND_BYTE,    8'h00,   8'd0,   8'd0},
      '{"2",   1'b1, 1'b0, vtp_pkg::KIND_BYTE,    8'h00,   8'd0,   8'd0},
      '{"5",   1'b1, 1'b0, vtp_pkg::KIND_BYTE,    8'h00,   8'd0,   8'd0},
      '{"5",   1'b1, 1'b0, vtp_pkg::KIND_BYTE,    8'h00,   8'd0,   8'd0},
      '{"A",   1'b1, 1'b1, vtp_pkg::KIND_UP,      8'h00,   8'd255, 8'd0},  // largest count
      '{CH_ESC, 1'b0, 1'b0, vtp_pkg::KIND_BYTE,   8'h00,   8'd0,   8'd0},
      '{"[",   1'b0, 1'b0, vtp_pkg::KIND_BYTE,    8'h00,   8'd0,   8'd0},
      '{"S",   1'b1, 1'b1, vtp_pkg::KIND_SU,      8'h00,   8'd1,   8'd0},  // full region
      '{CH_ESC, 1'b0, 1'b0, vtp_pkg::KIND_BYTE,   8'h00,   8'd0,   8'd0},
      '{"c",   1'b0, 1'b0, vtp_pkg::KIND_BYTE,    8'h00,   8'd0,   8'd0},  // RIS: two beats
      '{CH_ESC, 1'b1, 1'b0, vtp_pkg::KIND_BYTE,   8'h00,   8'd0,   8'd0},
      '{"x",   1'b1, 1'b0, vtp_pkg::KIND_BYTE,    8'h00,   8'd0,   8'd0}   // unknown escape
    };

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_byte(dir_rows[i].rx, dir_rows[i].pinned, dir_rows[i].has_res,
                '{dir_rows[i].kind, dir_rows[i].ob, dir_rows[i].a, dir_rows[i].b, 1'b1});

    // Random phases across row counts: tallest, one row, zero (wraps), mid, reset value.
    set_rows(8'd255);
    random_phase(PHASE_ITEMS);
    set_rows(8'd1);
    random_phase(PHASE_ITEMS);
    set_rows(8'd0);
    random_phase(PHASE_ITEMS);
    set_rows(8'($urandom_range(2, 254)));
    random_phase(PHASE_ITEMS);
    set_rows(vtp_pkg::SCREEN_ROWS_RESET);
    random_phase(PHASE_ITEMS);

    settle(DRAIN_CYCLES);

    $display("covered %0d bytes in, %0d result beats checked, %0d row-count writes",
             bytes_in, beats_out, rows_writes);
    $display("row counts 24, 255, 1, 0 and one random; %0d mismatches", fails);
    if (fails == 0 && exp_q.size() == 0) begin
      $display("PASS vt100_escape_parser_top");
    end else begin
      $display("FAIL vt100_escape_parser_top");
    end
    $finish;
  end

endmodule
